// ----- src/vrp_pkg.sv -----
`default_nettype none
package vrp_pkg;

   localparam int VERSION_BITS = 64;
   localparam int CHAR_BITS = 16;
   localparam int ACCUM_BITS = 17;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [3:0] status_type;

   localparam status_type ST_OK = 4'd0;
   localparam status_type ST_FORMAT = 4'd1;
   localparam status_type ST_EMPTY = 4'd2;
   localparam status_type ST_TOO_MANY = 4'd3;
   localparam status_type ST_SPACE = 4'd4;
   localparam status_type ST_EMPTY_FIELD = 4'd5;
   localparam status_type ST_TOO_LARGE = 4'd6;
   localparam status_type ST_NAN = 4'd7;
   localparam status_type ST_OVERFLOW = 4'd8;
   localparam status_type ST_UNDERFLOW = 4'd9;
   localparam status_type ST_MIN_MAX = 4'd10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING = 2'd2;

   localparam logic [CHAR_BITS-1:0] CH_LPAREN = 16'h0028;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN = 16'h0029;
   localparam logic [CHAR_BITS-1:0] CH_LBRACK = 16'h005B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACK = 16'h005D;
   localparam logic [CHAR_BITS-1:0] CH_COMMA = 16'h002C;
   localparam logic [CHAR_BITS-1:0] CH_DOT = 16'h002E;
   localparam logic [CHAR_BITS-1:0] CH_ZERO = 16'h0030;
   localparam logic [CHAR_BITS-1:0] CH_NINE = 16'h0039;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 16'h0020;
   localparam logic [CHAR_BITS-1:0] CH_TAB = 16'h0009;
   localparam logic [CHAR_BITS-1:0] CH_CR = 16'h000D;

   typedef struct packed {
      status_type status;
      logic [VERSION_BITS-1:0] min_version;
      logic [VERSION_BITS-1:0] max_version;
      logic low_exclusive;
      logic high_exclusive;
   } job_type;

endpackage
`default_nettype wire

// ----- src/vrp_if.sv -----
`default_nettype none
interface vrp_req_if;
   logic valid;
   logic ready;
   logic [15:0] ch;
   logic string_end;
   modport source (output valid, output ch, output string_end, input ready);
   modport sink (input valid, input ch, input string_end, output ready);
endinterface

interface vrp_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] status;
   logic [63:0] min_version;
   logic [63:0] max_version;
   modport source (output valid, output status, output min_version, output max_version,
                   input ready);
   modport sink (input valid, input status, input min_version, input max_version,
                 output ready);
endinterface
`default_nettype wire

// ----- src/vrp_scan.sv -----
`default_nettype none
module vrp_scan
   import vrp_pkg::*;
#(
   parameter int FIELD_COUNT = 4,
   parameter int FIELD_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   vrp_req_if.sink req_chan,
   input wire logic csr_we,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [VERSION_BITS-1:0] csr_wdata,
   input wire logic job_ready,
   output logic job_valid,
   output job_type job
);

   localparam logic [ACCUM_BITS-1:0] FIELD_MAX = ACCUM_BITS'((1 << FIELD_BITS) - 1);
   localparam logic [ACCUM_BITS-1:0] ACCUM_SAT = ACCUM_BITS'(65536);
   localparam logic [2:0] LAST_FIELD = 3'(FIELD_COUNT - 1);

   typedef struct packed {
      status_type err;
      logic [VERSION_BITS-1:0] pv;
   } tok_type;

   function automatic tok_type end_field(input status_type terr, input logic fspace,
                                         input logic ffilled, input logic [ACCUM_BITS-1:0] acc,
                                         input logic fnd, input logic [2:0] idx,
                                         input logic [VERSION_BITS-1:0] pv);
      tok_type r;
      logic [2:0] rel;
      logic [6:0] sh;
      r.err = terr;
      r.pv = pv;
      rel = LAST_FIELD - idx;
      sh = 7'(rel * FIELD_BITS);
      if (terr == ST_OK) begin
         if (fspace) r.err = ST_SPACE;
         else if (!ffilled) r.err = ST_EMPTY_FIELD;
         else if (acc > FIELD_MAX) r.err = ST_TOO_LARGE;
         else if (fnd) r.err = ST_NAN;
         else if (idx <= LAST_FIELD) r.pv = pv | (VERSION_BITS'(acc) << sh);
      end
      return r;
   endfunction

   logic mode_ff;
   logic [VERSION_BITS-1:0] floor_ff, ceil_ff;
   logic seen_ff, seen_in, close_ff, close_in, comma_ff, comma_in;
   logic lx_ff, lx_in, hx_ff, hx_in, single_ff, single_in;
   logic open_ff, open_in, gap_ff, gap_in, given_ff, given_in;
   logic filled_ff, filled_in, fspace_ff, fspace_in, nd_ff, nd_in;
   logic [2:0] idx_ff, idx_in;
   logic [ACCUM_BITS-1:0] acc_ff, acc_in;
   logic [VERSION_BITS-1:0] pv_ff, pv_in, low_ff, low_in;
   status_type err_ff, err_in, terr_ff, terr_in;

   logic accept, do_tok, is_space, is_digit;
   logic [CHAR_BITS-1:0] c;
   logic [20:0] prod;
   tok_type t;
   job_type rec;

   assign req_chan.ready = job_ready;
   assign accept = req_chan.valid && job_ready;
   assign c = req_chan.ch;
   assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 21'(c - CH_ZERO);

   always_comb begin
      seen_in = seen_ff; close_in = close_ff; comma_in = comma_ff;
      lx_in = lx_ff; hx_in = hx_ff; single_in = single_ff;
      open_in = open_ff; gap_in = gap_ff; given_in = given_ff;
      filled_in = filled_ff; fspace_in = fspace_ff; nd_in = nd_ff;
      idx_in = idx_ff; acc_in = acc_ff; pv_in = pv_ff; low_in = low_ff;
      err_in = err_ff; terr_in = terr_ff;
      do_tok = 1'b0;
      t = end_field(terr_ff, fspace_ff, filled_ff, acc_ff, nd_ff, idx_ff, pv_ff);
      rec = '0;
      if (accept && !req_chan.string_end) begin
         if (err_ff == ST_OK) begin
            if (is_space) begin
               if (open_ff) gap_in = 1'b1;
            end else if (mode_ff) begin
               seen_in = 1'b1;
               do_tok = 1'b1;
            end else if (close_ff) begin
               err_in = ST_FORMAT;
            end else begin
               seen_in = 1'b1;
               if (c == CH_LPAREN || c == CH_LBRACK) begin
                  if (seen_ff) err_in = ST_FORMAT;
                  else if (c == CH_LPAREN) lx_in = 1'b1;
               end else if (c == CH_RPAREN || c == CH_RBRACK) begin
                  close_in = 1'b1;
                  if (c == CH_RPAREN) hx_in = 1'b1;
                  single_in = !comma_ff;
               end else if (c == CH_COMMA) begin
                  if (comma_ff) begin
                     err_in = ST_FORMAT;
                  end else begin
                     comma_in = 1'b1;
                     if (open_ff) begin
                        if (t.err != ST_OK) err_in = t.err;
                        else begin
                           low_in = t.pv;
                           given_in = 1'b1;
                        end
                     end
                     open_in = 1'b0; gap_in = 1'b0; idx_in = '0; pv_in = '0;
                     terr_in = ST_OK; acc_in = '0; filled_in = 1'b0;
                     fspace_in = 1'b0; nd_in = 1'b0;
                  end
               end else begin
                  do_tok = 1'b1;
               end
            end
            if (do_tok) begin
               fspace_in = fspace_ff | gap_ff;
               gap_in = 1'b0;
               open_in = 1'b1;
               if (terr_ff == ST_OK) begin
                  if (c == CH_DOT) begin
                     t = end_field(terr_ff, fspace_in, filled_ff, acc_ff, nd_ff, idx_ff, pv_ff);
                     terr_in = t.err;
                     pv_in = t.pv;
                     if (t.err == ST_OK) begin
                        idx_in = idx_ff + 3'd1;
                        if (idx_ff >= LAST_FIELD) terr_in = ST_TOO_MANY;
                        else begin
                           acc_in = '0; filled_in = 1'b0; fspace_in = 1'b0; nd_in = 1'b0;
                        end
                     end
                  end else begin
                     filled_in = 1'b1;
                     if (is_digit) begin
                        if (!nd_ff) acc_in = (prod > 21'(ACCUM_SAT)) ? ACCUM_SAT
                                                                    : prod[ACCUM_BITS-1:0];
                     end else begin
                        nd_in = 1'b1;
                     end
                  end
               end
            end
         end
      end else if (accept) begin
         if (err_ff != ST_OK) begin
            rec.status = err_ff;
         end else if (!seen_ff) begin
            rec.status = ST_EMPTY;
         end else if (mode_ff) begin
            rec.status = t.err;
            rec.min_version = t.pv;
            rec.max_version = t.pv;
         end else begin
            rec.min_version = given_ff ? low_ff : floor_ff;
            rec.max_version = ceil_ff;
            if (open_ff) begin
               if (t.err != ST_OK) rec.status = t.err;
               else begin
                  if (comma_ff) rec.max_version = t.pv;
                  else rec.min_version = t.pv;
                  if (single_ff) rec.max_version = comma_ff ? rec.min_version : t.pv;
               end
            end
            rec.low_exclusive = lx_ff;
            rec.high_exclusive = hx_ff;
         end
         if (rec.status != ST_OK) begin
            rec.min_version = '0;
            rec.max_version = '0;
            rec.low_exclusive = 1'b0;
            rec.high_exclusive = 1'b0;
         end
         seen_in = 1'b0; close_in = 1'b0; comma_in = 1'b0; lx_in = 1'b0; hx_in = 1'b0;
         single_in = 1'b0; open_in = 1'b0; gap_in = 1'b0; given_in = 1'b0;
         filled_in = 1'b0; fspace_in = 1'b0; nd_in = 1'b0; idx_in = '0; acc_in = '0;
         pv_in = '0; low_in = '0; err_in = ST_OK; terr_in = ST_OK;
      end
   end

   assign job_valid = accept && req_chan.string_end;
   assign job = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         floor_ff <= '0;
         ceil_ff <= '1;
         seen_ff <= 1'b0; close_ff <= 1'b0; comma_ff <= 1'b0; lx_ff <= 1'b0;
         hx_ff <= 1'b0; single_ff <= 1'b0; open_ff <= 1'b0; gap_ff <= 1'b0;
         given_ff <= 1'b0; filled_ff <= 1'b0; fspace_ff <= 1'b0; nd_ff <= 1'b0;
         idx_ff <= '0; acc_ff <= '0; pv_ff <= '0; low_ff <= '0;
         err_ff <= ST_OK; terr_ff <= ST_OK;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE: mode_ff <= csr_wdata[0];
               CSR_FLOOR: floor_ff <= csr_wdata;
               CSR_CEILING: ceil_ff <= csr_wdata;
               default: ;
            endcase
         end
         seen_ff <= seen_in; close_ff <= close_in; comma_ff <= comma_in; lx_ff <= lx_in;
         hx_ff <= hx_in; single_ff <= single_in; open_ff <= open_in; gap_ff <= gap_in;
         given_ff <= given_in; filled_ff <= filled_in; fspace_ff <= fspace_in; nd_ff <= nd_in;
         idx_ff <= idx_in; acc_ff <= acc_in; pv_ff <= pv_in; low_ff <= low_in;
         err_ff <= err_in; terr_ff <= terr_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/vrp_fifo.sv -----
`default_nettype none
module vrp_fifo
   import vrp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input job_type push_data,
   output logic not_full,
   input wire logic pop,
   output logic not_empty,
   output job_type pop_data
);

   job_type mem [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign not_full = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = mem[rd_ptr_ff];
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset) push |-> not_full)
      else $error("push into a full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- src/vrp_final.sv -----
`default_nettype none
module vrp_final
   import vrp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic job_valid,
   input job_type job,
   output logic job_pop,
   vrp_rsp_if.source rsp_chan
);

   logic s1_valid_ff;
   job_type s1_ff, s1_in;
   logic out_valid_ff;
   status_type out_status_ff, out_status_in;
   logic [VERSION_BITS-1:0] out_min_ff, out_min_in, out_max_ff, out_max_in;
   logic out_move, s1_move;

   assign out_move = !out_valid_ff || rsp_chan.ready;
   assign s1_move = !s1_valid_ff || out_move;
   assign job_pop = job_valid && s1_move;

   always_comb begin
      s1_in = job;
      s1_in.low_exclusive = 1'b0;
      s1_in.high_exclusive = 1'b0;
      if (job.low_exclusive && (&job.min_version)) s1_in.status = ST_OVERFLOW;
      else if (job.high_exclusive && (job.max_version == '0)) s1_in.status = ST_UNDERFLOW;
      if (job.low_exclusive) s1_in.min_version = job.min_version + VERSION_BITS'(1);
      if (job.high_exclusive) s1_in.max_version = job.max_version - VERSION_BITS'(1);
   end

   always_comb begin
      out_status_in = s1_ff.status;
      if (s1_ff.status == ST_OK && s1_ff.min_version > s1_ff.max_version)
         out_status_in = ST_MIN_MAX;
      out_min_in = (out_status_in == ST_OK) ? s1_ff.min_version : '0;
      out_max_in = (out_status_in == ST_OK) ? s1_ff.max_version : '0;
   end

   always_ff @(posedge clock) begin
      if (s1_move) s1_ff <= s1_in;
      if (out_move && s1_valid_ff) begin
         out_status_ff <= out_status_in;
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_move) s1_valid_ff <= job_valid;
         if (out_move) out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.status = out_status_ff;
   assign rsp_chan.min_version = out_min_ff;
   assign rsp_chan.max_version = out_max_ff;

endmodule
`default_nettype wire

// ----- src/version_range_parser_top.sv -----
// A result is registered in the queue, the bound-check stage and the output register in turn.
// Throughput: one beat per cycle while the queue has room; each updates the scanner state.
// A two-entry queue decouples the scanner from the two-stage bound check and output register.
// Reset is synchronous and active high; it clears the parse state and sets mode to range,
// the floor to zero and the ceiling to all ones.
`default_nettype none
module version_range_parser_top
   import vrp_pkg::*;
#(
   parameter int FIELD_COUNT = 4,
   parameter int FIELD_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   vrp_req_if.sink req_chan,
   vrp_rsp_if.source rsp_chan,
   input wire logic csr_we,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [VERSION_BITS-1:0] csr_wdata
);

   logic push, not_full, pop, not_empty;
   job_type push_data, pop_data;

   vrp_scan #(.FIELD_COUNT(FIELD_COUNT), .FIELD_BITS(FIELD_BITS)) u_scan (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .job_ready(not_full), .job_valid(push), .job(push_data)
   );

   vrp_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .not_full(not_full), .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
   );

   vrp_final u_final (
      .clock(clock), .reset(reset), .job_valid(not_empty), .job(pop_data),
      .job_pop(pop), .rsp_chan(rsp_chan)
   );

endmodule
`default_nettype wire

// ----- tb/tb_version_range_parser_top.sv -----
module tb_version_range_parser_top;
   import vrp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODE;
   logic [VERSION_BITS-1:0] csr_wdata = '0;

   vrp_req_if req_chan();
   vrp_rsp_if rsp_chan();

   version_range_parser_top DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct {
      status_type status;
      logic [63:0] min_version;
      logic [63:0] max_version;
   } bounds_type;

   bounds_type pending_bounds[$];
   int error_count = 0;
   int hold_cycles = 0;
   bit sink_random = 1'b1;

   // Predictor configuration and scanner state.
   bit cfg_single;
   logic [63:0] cfg_floor, cfg_ceiling;
   bit seen_content, close_seen, comma_seen, low_excl, high_excl, single_flag;
   bit token_open, gap_pending, low_given, fld_filled, fld_space, fld_nondigit;
   int unsigned fld_index, fld_accum;
   logic [63:0] part_ver, low_held;
   status_type first_err, token_err;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.ch = '0;
      req_chan.string_end = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic void clear_field();
      fld_accum = 0; fld_filled = 0; fld_space = 0; fld_nondigit = 0;
   endfunction

   function automatic void clear_token();
      token_open = 0; gap_pending = 0; fld_index = 0; part_ver = '0; token_err = ST_OK;
      clear_field();
   endfunction

   function automatic void clear_string();
      seen_content = 0; close_seen = 0; comma_seen = 0; low_excl = 0; high_excl = 0;
      single_flag = 0; low_given = 0; low_held = '0; first_err = ST_OK;
      clear_token();
   endfunction

   function automatic void commit_error(status_type e);
      if (first_err == ST_OK) first_err = e;
   endfunction

   function automatic void close_field();
      if (token_err != ST_OK) return;
      if (fld_space) token_err = ST_SPACE;
      else if (!fld_filled) token_err = ST_EMPTY_FIELD;
      else if (fld_accum > 65535) token_err = ST_TOO_LARGE;
      else if (fld_nondigit) token_err = ST_NAN;
      else if (fld_index < 4) part_ver |= 64'(fld_accum) << ((3 - fld_index) * 16);
   endfunction

   function automatic void field_char(logic [15:0] c);
      int unsigned v;
      if (gap_pending) begin
         gap_pending = 0; fld_space = 1;
      end
      token_open = 1;
      if (token_err != ST_OK) return;
      if (c == CH_DOT) begin
         close_field();
         if (token_err != ST_OK) return;
         fld_index++;
         if (fld_index >= 4) token_err = ST_TOO_MANY;
         else clear_field();
         return;
      end
      fld_filled = 1;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (!fld_nondigit) begin
            v = fld_accum * 10 + (c - CH_ZERO);
            fld_accum = (v > 65536) ? 65536 : v;
         end
      end else begin
         fld_nondigit = 1;
      end
   endfunction

   function automatic void predict_range(logic [15:0] c, bit term);
      bounds_type r;
      bit first;
      if (!term) begin
         if (first_err != ST_OK) return;
         if (c == 16'h20 || (c >= 16'h09 && c <= 16'h0D)) begin
            if (token_open) gap_pending = 1;
            return;
         end
         if (cfg_single) begin
            seen_content = 1; field_char(c); return;
         end
         if (close_seen) begin
            commit_error(ST_FORMAT); return;
         end
         first = !seen_content;
         seen_content = 1;
         if (c == CH_LPAREN || c == CH_LBRACK) begin
            if (!first) commit_error(ST_FORMAT);
            else if (c == CH_LPAREN) low_excl = 1;
         end else if (c == CH_RPAREN || c == CH_RBRACK) begin
            close_seen = 1;
            if (c == CH_RPAREN) high_excl = 1;
            single_flag = !comma_seen;
         end else if (c == CH_COMMA) begin
            if (comma_seen) begin
               commit_error(ST_FORMAT); return;
            end
            comma_seen = 1;
            if (token_open) begin
               close_field();
               if (token_err != ST_OK) begin
                  commit_error(token_err); return;
               end
               low_held = part_ver; low_given = 1;
            end
            clear_token();
         end else begin
            field_char(c);
         end
         return;
      end
      r.status = ST_OK; r.min_version = '0; r.max_version = '0;
      if (first_err != ST_OK) r.status = first_err;
      else if (!seen_content) r.status = ST_EMPTY;
      else if (cfg_single) begin
         close_field();
         if (token_err != ST_OK) r.status = token_err;
         else begin
            r.min_version = part_ver; r.max_version = part_ver;
         end
      end else begin
         r.min_version = low_given ? low_held : cfg_floor;
         r.max_version = cfg_ceiling;
         if (token_open) begin
            close_field();
            if (token_err != ST_OK) r.status = token_err;
            else begin
               if (comma_seen) r.max_version = part_ver;
               else r.min_version = part_ver;
               if (single_flag) r.max_version = r.min_version;
            end
         end
         if (r.status == ST_OK && low_excl) begin
            if (&r.min_version) r.status = ST_OVERFLOW;
            else r.min_version++;
         end
         if (r.status == ST_OK && high_excl) begin
            if (r.max_version == 0) r.status = ST_UNDERFLOW;
            else r.max_version--;
         end
         if (r.status == ST_OK && r.min_version > r.max_version) r.status = ST_MIN_MAX;
      end
      if (r.status != ST_OK) begin
         r.min_version = '0; r.max_version = '0;
      end
      pending_bounds.push_back(r);
      clear_string();
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 19) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The beat stays offered after acceptance; the next call replaces it or drops valid, as an idle task does.
   task automatic send_beat(input logic [15:0] c, input bit term);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch <= c;
      req_chan.string_end <= term;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_range(c, term);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(16'(s[i]), 1'b0);
      send_beat(16'(CH_ZERO), 1'b1);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_bounds.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] val);
      req_chan.valid <= 1'b0;
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODE) cfg_single = val[0];
      else if (idx == CSR_FLOOR) cfg_floor = val;
      else if (idx == CSR_CEILING) cfg_ceiling = val;
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (sink_random) begin
         if ($urandom_range(0, 199) == 0) hold_cycles <= $urandom_range(10, 40);
         rsp_chan.ready <= ($urandom_range(0, 9) < 7);
      end else rsp_chan.ready <= 1'b1;
   end

   always @(posedge clock) begin
      bounds_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bounds.size() == 0) report("unexpected beat", rsp_chan.status, 0);
         else begin
            w = pending_bounds.pop_front();
            if (rsp_chan.status !== w.status) report("status", rsp_chan.status, w.status);
            if (rsp_chan.min_version !== w.min_version)
               report("min_version", rsp_chan.min_version, w.min_version);
            if (rsp_chan.max_version !== w.max_version)
               report("max_version", rsp_chan.max_version, w.max_version);
         end
      end
   end

   task automatic test_directed();
      send_text("[1.2.3.4,5.6.7.8]");
      send_text(" (1.0 , 2.0) ");
      send_text("[65535.65535.65535.65535]");
      send_text("(65535.65535.65535.65535,");
      send_text(",0)");
      send_text("");
      send_text("   ");
      send_text("1.2.3.4.5");
      send_text("1. 2");
      send_text("1..2");
      send_text("65536");
      send_text("99999x");
      send_text("1a");
      send_text("-1");
      send_text("2,1");
      send_text("[1,2,3]");
      send_text("[1]x");
      send_text("1[");
      send_text(",");
      send_text("\t1.2\r");
      send_beat(16'hFFFF, 1'b0);
      send_beat(16'h0000, 1'b1);
      wait_drained();
      write_csr(CSR_MODE, 64'd1);
      send_text("7.8.9.10");
      send_text("[1]");
      send_text("1,2");
      wait_drained();
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_MODE, 64'd0);
      write_csr(CSR_FLOOR, '1);
      write_csr(CSR_CEILING, '0);
      send_text(",");
      send_text("(,");
      send_text(",)");
      send_text("[,]");
      wait_drained();
      write_csr(CSR_FLOOR, {$urandom, $urandom});
      write_csr(CSR_CEILING, {$urandom, $urandom});
      send_text("(,)");
      send_text("1.2,");
      wait_drained();
      write_csr(CSR_FLOOR, '0);
      write_csr(CSR_CEILING, '1);
   endtask

   function automatic string random_version();
      string s, t;
      int n;
      n = $urandom_range(1, 4);
      s = "";
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: t = $sformatf("%0d", $urandom_range(0, 9));
            1: t = $sformatf("%0d", $urandom_range(0, 65535));
            2: t = $sformatf("%0d", 65535 - $urandom_range(0, 2));
            default: t = $sformatf("%0d", $urandom_range(0, 999));
         endcase
         s = {s, (i != 0) ? "." : "", t};
      end
      return s;
   endfunction

   function automatic string random_range();
      string s;
      s = ($urandom_range(0, 3) == 0) ? " " : "";
      case ($urandom_range(0, 2))
         0: s = {s, "["};
         1: s = {s, "("};
         default: ;
      endcase
      if ($urandom_range(0, 4) != 0) s = {s, random_version()};
      if ($urandom_range(0, 3) != 0) begin
         s = {s, ($urandom_range(0, 1) != 0) ? "," : " , "};
         if ($urandom_range(0, 4) != 0) s = {s, random_version()};
      end
      case ($urandom_range(0, 2))
         0: s = {s, "]"};
         1: s = {s, ")"};
         default: ;
      endcase
      return s;
   endfunction

   task automatic send_noise(input int n);
      logic [15:0] c;
      string alphabet;
      alphabet = " 0123456789.,()[]x\t";
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: c = 16'($urandom);
            1: c = 16'($urandom_range(16'h09, 16'h5D));
            default: c = 16'(alphabet[$urandom_range(0, 18)]);
         endcase
         send_beat(c, 1'b0);
      end
      send_beat(16'($urandom), 1'b1);
   endtask

   task automatic test_random(input int beats);
      int sent;
      int n;
      string s;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(0, 12);
            send_noise(n);
            sent += n + 1;
         end else begin
            s = cfg_single ? random_version() : random_range();
            send_text(s);
            sent += s.len() + 1;
         end
         if ($urandom_range(0, 80) == 0) begin
            wait_drained();
            write_csr(CSR_MODE, 64'($urandom_range(0, 1)));
            write_csr(CSR_FLOOR, ($urandom_range(0, 1) != 0) ? 64'($urandom) : '0);
            write_csr(CSR_CEILING, ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '1);
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      int n;
      n = 0;
      hold_cycles = 200;
      while (n < 60) begin
         send_text("1,2");
         n += 4;
      end
      wait_drained();
      sink_random = 1'b0;
      for (int i = 0; i < 10; i++) send_text("[3.4,5]");
      wait_drained();
      sink_random = 1'b1;
   endtask

   initial begin
      cfg_single = 0; cfg_floor = '0; cfg_ceiling = '1;
      clear_string();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random(900);
      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("version_range_parser_top: match");
      else $display("version_range_parser_top: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("version_range_parser_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/vrp_pkg.sv
src/vrp_if.sv
src/vrp_scan.sv
src/vrp_fifo.sv
src/vrp_final.sv
src/version_range_parser_top.sv
tb/tb_version_range_parser_top.sv
